### design/sacf_pkg.sv
// Shared types and constants for the set-associative cache tag simulator.
`timescale 1ns / 1ps
`default_nettype none

package sacf_pkg;

    // Tags are kept in 62 bits whatever the address width.
    localparam int TAG_W = 62;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd2;

    localparam logic [2:0] RST_SET_BITS    = 3'd4;
    localparam logic [3:0] RST_WAYS_IN_USE = 4'd1;
    localparam logic [5:0] RST_OFFSET_BITS = 6'd4;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] ways_in_use;
        logic [5:0] offset_bits;
    } t_cfg;

    typedef struct packed {
        logic        strobe;
        logic [1:0]  outcome;
        logic        last;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } t_result;

endpackage

`default_nettype wire

### design/sacf_front.sv
// Front end: accepts access requests and splits the address into set and tag.
`timescale 1ns / 1ps
`default_nettype none

module sacf_front #(
    parameter int MAX_SET_BITS = 6,
    parameter int ADDR_WIDTH   = 64
) (
    input  var sacf_pkg::t_cfg              i_cfg,
    input  wire                             i_start,
    input  wire  [1:0]                      i_cmd,
    input  wire  [63:0]                     i_address,
    input  wire                             i_full,
    output logic                            o_push,
    output logic [MAX_SET_BITS+sacf_pkg::TAG_W:0] o_entry
);
    import sacf_pkg::*;

    localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_WIDTH);

    logic [63:0] masked;
    logic [63:0] shifted;
    logic [63:0] set_mask;
    logic [63:0] tag_full;
    logic [2:0]  sb_eff;

    always_comb begin
        if (32'(i_cfg.set_bits) > MAX_SET_BITS) begin
            sb_eff = 3'(MAX_SET_BITS);
        end else begin
            sb_eff = i_cfg.set_bits;
        end
        masked   = i_address & ADDR_MASK;
        shifted  = masked >> i_cfg.offset_bits;
        set_mask = (64'd1 << sb_eff) - 64'd1;
        // Shifting in two steps saturates to zero once the fields cover the address.
        tag_full = shifted >> sb_eff;
    end

    assign o_push  = i_start && !i_full;
    assign o_entry = {(i_cmd == CMD_MODIFY),
                      shifted[MAX_SET_BITS-1:0] & set_mask[MAX_SET_BITS-1:0],
                      tag_full[TAG_W-1:0]};

endmodule

`default_nettype wire

### design/sacf_queue.sv
// Small first-in first-out queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module sacf_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/sacf_back.sv
// Back end: tag lookup, line fill or replacement, and running totals.
`timescale 1ns / 1ps
`default_nettype none

module sacf_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  var sacf_pkg::t_cfg                    i_cfg,
    input  wire                                   i_q_valid,
    input  wire  [MAX_SET_BITS+sacf_pkg::TAG_W:0] i_q_data,
    output logic                                  o_pop,
    output sacf_pkg::t_result                     o_result
);
    import sacf_pkg::*;

    localparam int SET_W    = MAX_SET_BITS;
    localparam int NUM_SETS = 1 << SET_W;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOK   = 2'd1;
    localparam logic [1:0] S_SECOND = 2'd2;

    // Tag rows hold every way of a set; fill count and oldest pointer per set.
    logic [MAX_WAYS-1:0][TAG_W-1:0] mem_tag  [NUM_SETS];
    logic [CNT_W-1:0]               mem_fill [NUM_SETS];
    logic [WAY_W-1:0]               mem_old  [NUM_SETS];
    logic [NUM_SETS-1:0]            r_seen;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic                           r_mod;
    logic [SET_W-1:0]               r_set;
    logic [TAG_W-1:0]               r_tag;
    logic [MAX_WAYS-1:0][TAG_W-1:0] r_row;
    logic [CNT_W-1:0]               r_fill_raw;
    logic [WAY_W-1:0]               r_old_raw;
    logic                           r_ok;
    logic [31:0]                    r_hits;
    logic [31:0]                    r_misses;
    logic [31:0]                    r_evicts;
    logic                           r_strobe;
    logic [1:0]                     r_outcome;
    logic                           r_last;

    logic [SET_W-1:0]               q_set;
    logic [4:0]                     ways_x;
    logic [CNT_W-1:0]               w_eff;
    logic [CNT_W-1:0]               fill;
    logic [WAY_W-1:0]               old;
    logic                           hit;
    logic                           evict;
    logic [WAY_W-1:0]               victim;
    logic [CNT_W-1:0]               n_fill;
    logic [WAY_W-1:0]               n_old;
    logic [MAX_WAYS-1:0][TAG_W-1:0] n_row;
    logic [1:0]                     outcome;

    assign q_set = i_q_data[TAG_W +: SET_W];
    assign o_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        ways_x = {1'b0, i_cfg.ways_in_use};
        if (ways_x == 5'd0) begin
            w_eff = CNT_W'(1);
        end else if (32'(ways_x) > MAX_WAYS) begin
            w_eff = CNT_W'(MAX_WAYS);
        end else begin
            w_eff = CNT_W'(ways_x);
        end

        // A set never written reads as empty with its pointer at way zero.
        fill = r_ok ? r_fill_raw : '0;
        old  = r_ok ? r_old_raw : '0;

        // Ways fill in order, so a way is valid exactly when it lies below the fill count.
        hit = 1'b0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if ((CNT_W'(i) < w_eff) && (CNT_W'(i) < fill) && (r_row[i] == r_tag)) begin
                hit = 1'b1;
            end
        end

        evict  = !hit && (fill >= w_eff);
        n_fill = fill;
        n_old  = old;
        victim = '0;
        if (!hit) begin
            if (!evict) begin
                victim = WAY_W'(fill);
                n_fill = fill + 1'b1;
            end else begin
                victim = (CNT_W'(old) >= w_eff) ? '0 : old;
                n_old  = ((CNT_W'(victim) + 1'b1) >= w_eff) ? '0 : victim + 1'b1;
            end
        end

        n_row = r_row;
        if (!hit) begin
            n_row[victim] = r_tag;
        end

        if (hit) begin
            outcome = OUT_HIT;
        end else if (evict) begin
            outcome = OUT_EVICT;
        end else begin
            outcome = OUT_MISS;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:   n_state = i_q_valid ? S_LOOK : S_IDLE;
            S_LOOK:   n_state = r_mod ? S_SECOND : S_IDLE;
            S_SECOND: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Set memories: one row read when a request leaves the queue, one written after lookup.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_row      <= mem_tag[q_set];
            r_fill_raw <= mem_fill[q_set];
            r_old_raw  <= mem_old[q_set];
            r_ok       <= r_seen[q_set];
            r_mod      <= i_q_data[TAG_W+SET_W];
            r_set      <= q_set;
            r_tag      <= i_q_data[TAG_W-1:0];
        end
        if (r_state == S_LOOK) begin
            mem_tag[r_set]  <= n_row;
            mem_fill[r_set] <= n_fill;
            mem_old[r_set]  <= n_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seen    <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
            r_strobe  <= 1'b0;
            r_outcome <= OUT_HIT;
            r_last    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (r_state == S_LOOK) begin
                r_seen[r_set] <= 1'b1;
                r_strobe      <= 1'b1;
                r_outcome     <= outcome;
                r_last        <= !r_mod;
                if (hit) begin
                    r_hits <= (r_hits == 32'hFFFF_FFFF) ? r_hits : r_hits + 32'd1;
                end else begin
                    r_misses <= (r_misses == 32'hFFFF_FFFF) ? r_misses : r_misses + 32'd1;
                end
                if (evict) begin
                    r_evicts <= (r_evicts == 32'hFFFF_FFFF) ? r_evicts : r_evicts + 32'd1;
                end
            end else if (r_state == S_SECOND) begin
                // The line is resident after the first half, so the store half always hits.
                r_strobe  <= 1'b1;
                r_outcome <= OUT_HIT;
                r_last    <= 1'b1;
                r_hits    <= (r_hits == 32'hFFFF_FFFF) ? r_hits : r_hits + 32'd1;
            end
        end
    end

    assign o_result.strobe      = r_strobe;
    assign o_result.outcome     = r_outcome;
    assign o_result.last        = r_last;
    assign o_result.hit_total   = r_hits;
    assign o_result.miss_total  = r_misses;
    assign o_result.evict_total = r_evicts;

endmodule

`default_nettype wire

### design/set_assoc_cache_fifo_sim.sv
// Top level of the set-associative cache tag simulator with FIFO replacement.
// A request passes through the queue, the read of its set's tag row and the lookup before
// its result is registered; a modify gives its second result in the cycle after the first.
// The back end takes a new request only after it has read the set's tag row and written
// back the updated row, and for a modify only after it has also given its second result.
// Reset (synchronous, active low) empties all sets, clears the totals and loads the
// registers with 4 set bits, 1 way and 4 offset bits. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_fifo_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_cmd,
    input  wire  [63:0] i_address,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [5:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_outcome,
    output logic        o_last,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total,
    output logic [31:0] o_evict_total
);
    import sacf_pkg::*;

    // Each queued request carries the modify flag, the set index and the tag.
    localparam int ENTRY_W = 1 + MAX_SET_BITS + TAG_W;
    localparam int Q_DEPTH = 2;

    t_cfg               r_cfg;
    t_result            result;
    logic               push;
    logic [ENTRY_W-1:0] entry;
    logic               q_full;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_data;
    logic               pop;

    // Configuration registers. The port never stalls; writes beyond the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits    <= RST_SET_BITS;
            r_cfg.ways_in_use <= RST_WAYS_IN_USE;
            r_cfg.offset_bits <= RST_OFFSET_BITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SET_BITS:    r_cfg.set_bits    <= i_cfg_data[2:0];
                CFG_WAYS_IN_USE: r_cfg.ways_in_use <= i_cfg_data[3:0];
                CFG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end takes a request whenever the queue has room.
    assign busy = q_full;

    sacf_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_front (
        .i_cfg     (r_cfg),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .i_address (i_address),
        .i_full    (q_full),
        .o_push    (push),
        .o_entry   (entry)
    );

    sacf_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // The back end owns the tag store and the totals, and drives the result registers.
    sacf_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_result  (result)
    );

    assign o_strobe      = result.strobe;
    assign o_outcome     = result.outcome;
    assign o_last        = result.last;
    assign o_hit_total   = result.hit_total;
    assign o_miss_total  = result.miss_total;
    assign o_evict_total = result.evict_total;

endmodule

`default_nettype wire
